>>> hdl/rufs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rufs_pkg
// types and constants shared by the radar serial frame synchroniser
// ----------------------------------------------------------------------------
package rufs_pkg;

    typedef logic [7:0] t_byte;

    // sliding search window and header sizes
    localparam int WIN_BYTES     = 10;
    localparam int WIN_REGS      = WIN_BYTES - 1;
    localparam int HDR_BYTES     = 8;
    localparam int ACK_HDR_BYTES = 4;
    localparam int FILL_W        = $clog2(WIN_BYTES + 1);
    localparam int LEN_W         = 9;
    localparam int LEN_BYTE_POS  = 4;
    localparam int ACK_CMD_POS   = 6;
    localparam int ACK_STAT_POS  = 7;

    localparam logic [FILL_W-1:0] LAST_FILL      = FILL_W'(WIN_BYTES - 1);
    localparam logic [LEN_W-1:0]  FRAME_OVERHEAD = LEN_W'(WIN_BYTES);
    localparam t_byte             ACK_OK         = 8'h01;

    localparam t_byte HDR_NORMAL [HDR_BYTES] =
        '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h0D, 8'h00, 8'h02, 8'hAA};
    localparam t_byte HDR_ENGI [HDR_BYTES] =
        '{8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'h23, 8'h00, 8'h01, 8'hAA};
    localparam t_byte HDR_ACK [ACK_HDR_BYTES] =
        '{8'hFD, 8'hFC, 8'hFB, 8'hFA};

    typedef enum logic [1:0] {
        KIND_NORMAL = 2'd0,
        KIND_ENGI   = 2'd1,
        KIND_ACK    = 2'd2
    } t_kind;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_match;

    typedef struct packed {
        t_kind            kind;
        logic [LEN_W-1:0] length;
        t_byte            ack_cmd;
        logic             ack_ok;
    } t_result;

endpackage
`default_nettype wire

>>> hdl/radar_uart_frame_sync_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radar_uart_frame_sync_core
// frame synchroniser for the serial byte stream of a presence radar
// ----------------------------------------------------------------------------
// Bytes from the radar link enter one item at a time on the input channel.
// The block locks onto normal data, engineering data and command-ack frames
// and, once a frame is complete, delivers one item giving its kind, total
// length, and for ack frames the acknowledged command and success flag.
// Each byte is held in the input register and processed on its way into the
// result register, which takes a frame report as the last byte of the frame
// leaves the input register. A new byte is accepted every cycle unless a
// finished result waits on a stalled output; the window compare and counter
// update are combinational. Bytes that form no header, and bytes inside a
// frame, produce no item. A finished result waiting on a stalled output
// holds back the byte in the input register, and the input stalls until the
// result is taken; an empty input register still takes one byte meanwhile.
// ----------------------------------------------------------------------------
module radar_uart_frame_sync_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // input channel
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire  [7:0]                      i_rx_byte,
    // result channel
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic [1:0]                      o_frame_kind,
    output logic [rufs_pkg::LEN_W-1:0]      o_frame_length,
    output logic [7:0]                      o_ack_command,
    output logic                            o_ack_success
);

    // input register
    logic             r_in_vld;
    rufs_pkg::t_byte  r_in_byte;

    // result register
    logic              r_out_vld;
    rufs_pkg::t_result r_out;

    logic              advance;
    logic              step;
    logic              emit;
    rufs_pkg::t_result result;

    // the held byte moves on when the result register is free or being taken
    assign advance = !r_out_vld || !i_stall;
    assign step    = r_in_vld && advance;
    assign o_stall = r_in_vld && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // window, header lock and frame counting
    rufs_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step && emit) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_frame_kind   = r_out.kind;
    assign o_frame_length = r_out.length;
    assign o_ack_command  = r_out.ack_cmd;
    assign o_ack_success  = r_out.ack_ok;

endmodule
`default_nettype wire

>>> hdl/rufs_hdr_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rufs_hdr_match
// compares the head of the search window with the three frame headers
// ----------------------------------------------------------------------------
module rufs_hdr_match (
    input  wire rufs_pkg::t_byte i_hdr [rufs_pkg::HDR_BYTES],
    output rufs_pkg::t_match     o_match
);

    logic hit_normal;
    logic hit_engi;
    logic hit_ack;

    always_comb begin
        hit_normal = 1'b1;
        hit_engi   = 1'b1;
        hit_ack    = 1'b1;
        for (int i = 0; i < rufs_pkg::HDR_BYTES; i++) begin
            if (i_hdr[i] != rufs_pkg::HDR_NORMAL[i]) hit_normal = 1'b0;
            if (i_hdr[i] != rufs_pkg::HDR_ENGI[i])   hit_engi   = 1'b0;
        end
        for (int i = 0; i < rufs_pkg::ACK_HDR_BYTES; i++) begin
            if (i_hdr[i] != rufs_pkg::HDR_ACK[i]) hit_ack = 1'b0;
        end

        // normal first, then engineering, then ack
        o_match.hit  = hit_normal | hit_engi | hit_ack;
        if (hit_normal) begin
            o_match.kind = rufs_pkg::KIND_NORMAL;
        end else if (hit_engi) begin
            o_match.kind = rufs_pkg::KIND_ENGI;
        end else begin
            o_match.kind = rufs_pkg::KIND_ACK;
        end
    end

endmodule
`default_nettype wire

>>> hdl/rufs_track.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rufs_track
// search window, header lock and frame byte counting, one byte per cycle while i_step is high
// ----------------------------------------------------------------------------
module rufs_track (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  wire rufs_pkg::t_byte i_byte,
    output logic                 o_emit,
    output rufs_pkg::t_result    o_result
);

    localparam int LW = rufs_pkg::LEN_W;

    rufs_pkg::t_byte              r_win [rufs_pkg::WIN_REGS];
    rufs_pkg::t_byte              n_win [rufs_pkg::WIN_REGS];
    logic [rufs_pkg::FILL_W-1:0]  r_fill, n_fill;
    logic                         r_in_frame, n_in_frame;
    logic [LW-1:0]                r_count, n_count;
    logic [LW-1:0]                r_expected, n_expected;
    rufs_pkg::t_kind              r_kind, n_kind;
    rufs_pkg::t_byte              r_ack_cmd, n_ack_cmd;
    logic                         r_ack_ok, n_ack_ok;

    rufs_pkg::t_byte  hdr [rufs_pkg::HDR_BYTES];
    rufs_pkg::t_match match;
    logic [LW-1:0]    count_inc;
    logic [LW-1:0]    exp_len;
    logic             new_ok;

    always_comb begin
        for (int i = 0; i < rufs_pkg::HDR_BYTES; i++) begin
            hdr[i] = r_win[i];
        end
    end

    rufs_hdr_match u_match (
        .i_hdr   (hdr),
        .o_match (match)
    );

    assign count_inc = (r_count != '1) ? r_count + LW'(1) : r_count;
    assign exp_len   = rufs_pkg::FRAME_OVERHEAD + LW'(r_win[rufs_pkg::LEN_BYTE_POS]);
    assign new_ok    = (r_win[rufs_pkg::ACK_STAT_POS] == rufs_pkg::ACK_OK);

    always_comb begin
        n_win      = r_win;
        n_fill     = r_fill;
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_expected = r_expected;
        n_kind     = r_kind;
        n_ack_cmd  = r_ack_cmd;
        n_ack_ok   = r_ack_ok;
        o_emit     = 1'b0;
        o_result.kind    = r_kind;
        o_result.length  = count_inc;
        o_result.ack_cmd = (r_kind == rufs_pkg::KIND_ACK) ? r_ack_cmd : '0;
        o_result.ack_ok  = (r_kind == rufs_pkg::KIND_ACK) ? r_ack_ok : 1'b0;

        if (i_step) begin
            if (r_in_frame) begin
                n_count = count_inc;
                if (count_inc >= r_expected) begin
                    o_emit     = 1'b1;
                    n_in_frame = 1'b0;
                    n_fill     = '0;
                    n_count    = '0;
                end
            end else if (r_fill != rufs_pkg::LAST_FILL) begin
                // still filling the window
                for (int i = 0; i < rufs_pkg::WIN_REGS; i++) begin
                    if (r_fill == rufs_pkg::FILL_W'(i)) n_win[i] = i_byte;
                end
                n_fill = r_fill + rufs_pkg::FILL_W'(1);
            end else if (match.hit) begin
                n_kind     = match.kind;
                n_expected = exp_len;
                n_ack_cmd  = r_win[rufs_pkg::ACK_CMD_POS];
                n_ack_ok   = new_ok;
                n_fill     = '0;
                if (exp_len <= rufs_pkg::FRAME_OVERHEAD) begin
                    // zero length byte: frame ends on the byte that filled the window
                    o_emit           = 1'b1;
                    o_result.kind    = match.kind;
                    o_result.length  = rufs_pkg::FRAME_OVERHEAD;
                    o_result.ack_cmd = (match.kind == rufs_pkg::KIND_ACK) ?
                                       r_win[rufs_pkg::ACK_CMD_POS] : '0;
                    o_result.ack_ok  = (match.kind == rufs_pkg::KIND_ACK) ? new_ok : 1'b0;
                    n_count          = '0;
                end else begin
                    n_in_frame = 1'b1;
                    n_count    = rufs_pkg::FRAME_OVERHEAD;
                end
            end else begin
                // drop the oldest byte
                for (int i = 0; i < rufs_pkg::WIN_REGS - 1; i++) begin
                    n_win[i] = r_win[i + 1];
                end
                n_win[rufs_pkg::WIN_REGS - 1] = i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_in_frame <= 1'b0;
            r_count    <= '0;
        end else begin
            r_fill     <= n_fill;
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win      <= n_win;
        r_expected <= n_expected;
        r_kind     <= n_kind;
        r_ack_cmd  <= n_ack_cmd;
        r_ack_ok   <= n_ack_ok;
    end

endmodule
`default_nettype wire

>>> hdl/rufs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rufs_checker
// port-level checks for the radar frame synchroniser
// ----------------------------------------------------------------------------
module rufs_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         o_stall,
    input wire                         o_valid,
    input wire                         i_stall,
    input wire [1:0]                   o_frame_kind,
    input wire [rufs_pkg::LEN_W-1:0]   o_frame_length,
    input wire [7:0]                   o_ack_command,
    input wire                         o_ack_success
);

    // both channels come out of reset empty
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("channel active after reset");

    // data frame headers carry fixed length bytes; ack lengths lie from 10 to 265
    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_frame_kind == rufs_pkg::KIND_NORMAL && o_frame_length == 9'd23) ||
            (o_frame_kind == rufs_pkg::KIND_ENGI && o_frame_length == 9'd45) ||
            (o_frame_kind == rufs_pkg::KIND_ACK && o_frame_length >= 9'd10 &&
             o_frame_length <= 9'd265))
        else $error("frame kind and length disagree");

    // ack fields are zero on data frames
    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_kind != rufs_pkg::KIND_ACK |->
            o_ack_command == 8'h00 && !o_ack_success)
        else $error("ack fields set on a data frame");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_kind) &&
            $stable(o_frame_length) && $stable(o_ack_command) && $stable(o_ack_success))
        else $error("stalled result changed");

endmodule

bind radar_uart_frame_sync_core rufs_checker u_rufs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_frame_kind   (o_frame_kind),
    .o_frame_length (o_frame_length),
    .o_ack_command  (o_ack_command),
    .o_ack_success  (o_ack_success)
);
`default_nettype wire

>>> dv/tb_radar_uart_frame_sync_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radar_uart_frame_sync_core
// self-checking bench for the radar serial frame synchroniser
// ----------------------------------------------------------------------------
// Feeds byte streams into the synchroniser: directed frames at the length
// extremes, near-miss headers and noise, then random mixes of well-formed
// frames, broken headers and noise under several idle and stall patterns.
// A behavioural tracker of the search window predicts each frame report on
// input acceptance; every report taken from the block is checked against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_radar_uart_frame_sync_core;

    localparam int QUIET_LIMIT  = 5000;   // cycles with no handshake at all
    localparam int TAIL_CYCLES  = 10;     // settle time after the last report
    localparam int SHOWN_FAULTS = 10;
    localparam int PHASE_BYTES  = 130;

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [7:0]                   i_rx_byte;
    logic                         o_valid;
    logic                         i_stall;
    logic [1:0]                   o_frame_kind;
    logic [rufs_pkg::LEN_W-1:0]   o_frame_length;
    logic [7:0]                   o_ack_command;
    logic                         o_ack_success;

    radar_uart_frame_sync_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_kind   (o_frame_kind),
        .o_frame_length (o_frame_length),
        .o_ack_command  (o_ack_command),
        .o_ack_success  (o_ack_success)
    );

    // 4 ns clock period
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    int send_idle_pct;      // chance per cycle that the sender holds off
    int recv_stall_pct;     // chance per cycle that the receiver stalls
    int fault_cnt;
    int quiet_cycles;
    int bytes_sent;

    // tracker copy of the synchroniser state
    rufs_pkg::t_byte            win_buf [rufs_pkg::WIN_BYTES];
    int                         win_fill;
    bit                         locked;
    logic [rufs_pkg::LEN_W-1:0] frame_cnt;
    logic [rufs_pkg::LEN_W-1:0] frame_len_due;
    rufs_pkg::t_kind            lock_kind;
    rufs_pkg::t_byte            lock_cmd;
    logic                       lock_ok;

    // frame reports predicted but not yet delivered, oldest first
    rufs_pkg::t_result          reports_due [$];

    // ------------------------------------------------------------------------
    // window tracker: consumes one byte, returns 1 with the report when a
    // frame completes on it
    // ------------------------------------------------------------------------
    function automatic bit predict_report(input rufs_pkg::t_byte b,
                                          output rufs_pkg::t_result rep);
        bit hit_norm;
        bit hit_engi;
        bit hit_ack;
        rep = '0;
        if (locked) begin
            // inside a frame: bytes are only counted
            if (frame_cnt != '1) frame_cnt++;
            if (frame_cnt < frame_len_due) return 1'b0;
        end else begin
            win_buf[win_fill] = b;
            win_fill++;
            if (win_fill < rufs_pkg::WIN_BYTES) return 1'b0;
            hit_norm = 1'b1;
            hit_engi = 1'b1;
            hit_ack  = 1'b1;
            for (int k = 0; k < rufs_pkg::HDR_BYTES; k++) begin
                if (win_buf[k] != rufs_pkg::HDR_NORMAL[k]) hit_norm = 1'b0;
                if (win_buf[k] != rufs_pkg::HDR_ENGI[k])   hit_engi = 1'b0;
            end
            for (int k = 0; k < rufs_pkg::ACK_HDR_BYTES; k++)
                if (win_buf[k] != rufs_pkg::HDR_ACK[k]) hit_ack = 1'b0;
            if (!(hit_norm || hit_engi || hit_ack)) begin
                // no header: drop the oldest byte and slide
                for (int k = 0; k < rufs_pkg::WIN_REGS; k++) win_buf[k] = win_buf[k+1];
                win_buf[rufs_pkg::WIN_REGS] = '0;
                win_fill = rufs_pkg::WIN_REGS;
                return 1'b0;
            end
            // normal beats engineering beats ack
            lock_kind     = hit_norm ? rufs_pkg::KIND_NORMAL :
                            (hit_engi ? rufs_pkg::KIND_ENGI : rufs_pkg::KIND_ACK);
            frame_len_due = rufs_pkg::FRAME_OVERHEAD +
                            rufs_pkg::LEN_W'(win_buf[rufs_pkg::LEN_BYTE_POS]);
            lock_cmd      = win_buf[rufs_pkg::ACK_CMD_POS];
            lock_ok       = (win_buf[rufs_pkg::ACK_STAT_POS] == rufs_pkg::ACK_OK);
            frame_cnt     = rufs_pkg::FRAME_OVERHEAD;
            if (frame_cnt < frame_len_due) begin
                locked = 1'b1;
                return 1'b0;
            end
            // zero-length ack completes on the byte that fills the window
        end
        rep.kind    = lock_kind;
        rep.length  = frame_cnt;
        rep.ack_cmd = (lock_kind == rufs_pkg::KIND_ACK) ? lock_cmd : '0;
        rep.ack_ok  = (lock_kind == rufs_pkg::KIND_ACK) ? lock_ok : 1'b0;
        win_fill  = 0;
        locked    = 1'b0;
        frame_cnt = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // monitor: predict on each accepted byte, check each accepted report
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        rufs_pkg::t_result rep;
        rufs_pkg::t_result due;
        if (i_rst_n) begin
            if (i_valid && !o_stall && predict_report(i_rx_byte, rep))
                reports_due.insert(reports_due.size(), rep);
            if (o_valid && !i_stall) begin
                if (reports_due.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= SHOWN_FAULTS)
                        $display("%0t unexpected report: kind %0d length %0d cmd %02h ok %0d",
                                 $realtime, o_frame_kind, o_frame_length,
                                 o_ack_command, o_ack_success);
                end else begin
                    due = reports_due.pop_front();
                    if (o_frame_kind !== due.kind || o_frame_length !== due.length ||
                        o_ack_command !== due.ack_cmd || o_ack_success !== due.ack_ok) begin
                        fault_cnt++;
                        if (fault_cnt <= SHOWN_FAULTS)
                            $display({"%0t report mismatch: exp kind %0d length %0d",
                                      " cmd %02h ok %0d, got kind %0d length %0d",
                                      " cmd %02h ok %0d"},
                                     $realtime, due.kind, due.length, due.ack_cmd,
                                     due.ack_ok, o_frame_kind, o_frame_length,
                                     o_ack_command, o_ack_success);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when neither channel moves for too long
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && !(i_valid && !o_stall) && !(o_valid && !i_stall)) begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_radar_uart_frame_sync_core: errors");
                $finish;
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // offer one item and hold it until accepted; starts and ends on a falling edge
    task automatic send_byte(input rufs_pkg::t_byte b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // hold off the sender until every predicted report has come out
    task automatic wait_all_reported();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (reports_due.size() != 0);
    endtask

    task automatic send_noise(input int n);
        for (int k = 0; k < n; k++) send_byte(rufs_pkg::t_byte'($urandom_range(255)));
    endtask

    // header bytes for a frame kind; the ack fields only matter for ack frames
    function automatic void build_header(input rufs_pkg::t_kind kind,
                                         input rufs_pkg::t_byte len,
                                         input rufs_pkg::t_byte cmd,
                                         input rufs_pkg::t_byte stat,
                                         output rufs_pkg::t_byte hdr [rufs_pkg::HDR_BYTES]);
        for (int k = 0; k < rufs_pkg::HDR_BYTES; k++)
            hdr[k] = rufs_pkg::t_byte'($urandom_range(255));
        case (kind)
            rufs_pkg::KIND_NORMAL: hdr = rufs_pkg::HDR_NORMAL;
            rufs_pkg::KIND_ENGI:   hdr = rufs_pkg::HDR_ENGI;
            default: begin
                for (int k = 0; k < rufs_pkg::ACK_HDR_BYTES; k++) hdr[k] = rufs_pkg::HDR_ACK[k];
                hdr[rufs_pkg::LEN_BYTE_POS] = len;
                hdr[rufs_pkg::ACK_CMD_POS]  = cmd;
                hdr[rufs_pkg::ACK_STAT_POS] = stat;
            end
        endcase
    endfunction

    // whole frame: header, two window fillers, then the length byte worth of payload
    task automatic send_frame(input rufs_pkg::t_kind kind, input rufs_pkg::t_byte len,
                              input rufs_pkg::t_byte cmd, input rufs_pkg::t_byte stat);
        rufs_pkg::t_byte hdr [rufs_pkg::HDR_BYTES];
        build_header(kind, len, cmd, stat, hdr);
        foreach (hdr[k]) send_byte(hdr[k]);
        send_noise(rufs_pkg::WIN_BYTES + int'(hdr[rufs_pkg::LEN_BYTE_POS]) -
                   rufs_pkg::HDR_BYTES);
    endtask

    // header with one byte spoilt, cut short at a random point
    task automatic send_broken_header(input rufs_pkg::t_kind kind);
        rufs_pkg::t_byte hdr [rufs_pkg::HDR_BYTES];
        int              span;
        int              bad;
        int              last;
        build_header(kind, rufs_pkg::t_byte'($urandom_range(255)),
                     rufs_pkg::t_byte'($urandom_range(255)),
                     rufs_pkg::t_byte'($urandom_range(255)), hdr);
        span = (kind == rufs_pkg::KIND_ACK) ? rufs_pkg::ACK_HDR_BYTES : rufs_pkg::HDR_BYTES;
        bad  = $urandom_range(span - 1);
        hdr[bad] = hdr[bad] ^ rufs_pkg::t_byte'($urandom_range(1, 255));
        last = $urandom_range(rufs_pkg::HDR_BYTES - 1, bad);
        for (int k = 0; k <= last; k++) send_byte(hdr[k]);
    endtask

    function automatic rufs_pkg::t_kind pick_kind();
        int r;
        r = $urandom_range(2);
        return (r == 0) ? rufs_pkg::KIND_NORMAL :
               ((r == 1) ? rufs_pkg::KIND_ENGI : rufs_pkg::KIND_ACK);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // ack frames with no payload report at once, length ten
    task automatic test_zero_length_ack();
        send_frame(rufs_pkg::KIND_ACK, 8'h00, 8'hFF, rufs_pkg::ACK_OK);
        send_frame(rufs_pkg::KIND_ACK, 8'h00, 8'h00, 8'h00);
    endtask

    // both data headers, which differ only in the length byte and the byte at index 6
    task automatic test_data_frames();
        send_frame(rufs_pkg::KIND_NORMAL, 8'h00, 8'h00, 8'h00);
        send_frame(rufs_pkg::KIND_ENGI, 8'h00, 8'h00, 8'h00);
    endtask

    // short acks and the longest ack, success and failure status
    task automatic test_ack_lengths();
        send_frame(rufs_pkg::KIND_ACK, 8'h01, 8'hA5, rufs_pkg::ACK_OK);
        send_frame(rufs_pkg::KIND_ACK, 8'h02, 8'h5A, 8'hFE);
        send_frame(rufs_pkg::KIND_ACK, 8'hFF, 8'h61, 8'h02);
    endtask

    // extreme bytes and near-miss headers must not lock; a good frame after resyncs
    task automatic test_noise_and_near_miss();
        rufs_pkg::t_byte hdr [rufs_pkg::HDR_BYTES];
        send_byte(8'h00);
        send_byte(8'hFF);
        // normal header with the length byte off by one
        hdr = rufs_pkg::HDR_NORMAL;
        hdr[rufs_pkg::LEN_BYTE_POS] = 8'h0E;
        foreach (hdr[k]) send_byte(hdr[k]);
        // ack header missing its last byte
        for (int k = 0; k < rufs_pkg::ACK_HDR_BYTES - 1; k++) send_byte(rufs_pkg::HDR_ACK[k]);
        send_noise(3);
        send_frame(rufs_pkg::KIND_NORMAL, 8'h00, 8'h00, 8'h00);
    endtask

    // sender pauses until everything has drained, then resumes mid-stream
    task automatic test_drain_pause();
        send_frame(rufs_pkg::KIND_ACK, 8'h03, 8'h10, rufs_pkg::ACK_OK);
        wait_all_reported();
        send_frame(rufs_pkg::KIND_ENGI, 8'h00, 8'h00, 8'h00);
    endtask

    // mostly well-formed frames with random content, some broken headers and noise
    task automatic test_random_mix(input int idle_pct, input int stall_pct);
        int start;
        int r;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES) begin
            r = $urandom_range(99);
            if (r < 20)
                send_frame(rufs_pkg::KIND_NORMAL, 8'h00, 8'h00, 8'h00);
            else if (r < 30)
                send_frame(rufs_pkg::KIND_ENGI, 8'h00, 8'h00, 8'h00);
            else if (r < 75)
                send_frame(rufs_pkg::KIND_ACK,
                           ($urandom_range(99) < 4) ?
                               rufs_pkg::t_byte'($urandom_range(200, 255)) :
                               rufs_pkg::t_byte'($urandom_range(20)),
                           rufs_pkg::t_byte'($urandom_range(255)),
                           ($urandom_range(1)) ? rufs_pkg::ACK_OK :
                                                 rufs_pkg::t_byte'($urandom_range(255)));
            else if (r < 90)
                send_broken_header(pick_kind());
            else
                send_noise($urandom_range(1, 8));
            if ($urandom_range(99) < 5) wait_all_reported();
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_rx_byte      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fault_cnt      = 0;
        quiet_cycles   = 0;
        bytes_sent     = 0;
        win_buf        = '{default: '0};
        win_fill       = 0;
        locked         = 1'b0;
        frame_cnt      = '0;
        frame_len_due  = '0;
        lock_kind      = rufs_pkg::KIND_NORMAL;
        lock_cmd       = '0;
        lock_ok        = 1'b0;

        // synchronous reset held, then released on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part with no idling
        test_zero_length_ack();
        test_data_frames();
        test_ack_lengths();
        test_noise_and_near_miss();
        test_drain_pause();

        // random part under each idle pattern
        test_random_mix(0, 0);
        test_random_mix(78, 0);
        test_random_mix(0, 78);
        test_random_mix(29, 29);

        // drain, then let the pipeline settle
        recv_stall_pct = 0;
        wait_all_reported();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        fault_cnt += reports_due.size();

        if (fault_cnt == 0)
            $display("tb_radar_uart_frame_sync_core: clean");
        else
            $display("tb_radar_uart_frame_sync_core: errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/rufs_pkg.sv
hdl/rufs_hdr_match.sv
hdl/rufs_track.sv
hdl/radar_uart_frame_sync_core.sv
hdl/rufs_checker.sv
dv/tb_radar_uart_frame_sync_core.sv
